### rtl/kmh_pkg.sv
// ----------------------------------------------------------------------------
// kmh_pkg
// Shared types, constants and the SipRound function of the keyed hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmh_pkg;

    typedef logic [63:0] t_kmh_word;

    // Four SipHash state words
    typedef struct packed {
        t_kmh_word v0;
        t_kmh_word v1;
        t_kmh_word v2;
        t_kmh_word v3;
    } t_kmh_lanes;

    // One classified request, passed from the front end to the round engine
    typedef struct packed {
        logic      start;
        logic      last;
        t_kmh_word block;
    } t_kmh_entry;

    localparam int unsigned KMH_QUEUE_DEPTH = 4;

    localparam int unsigned KMH_CFG_IDX_W = 2;
    localparam logic [KMH_CFG_IDX_W-1:0] KMH_CFG_KEY_LOW  = 2'd0;
    localparam logic [KMH_CFG_IDX_W-1:0] KMH_CFG_KEY_HIGH = 2'd1;

    localparam t_kmh_word KMH_IV0 = 64'h736f6d6570736575;
    localparam t_kmh_word KMH_IV1 = 64'h646f72616e646f6d;
    localparam t_kmh_word KMH_IV2 = 64'h6c7967656e657261;
    localparam t_kmh_word KMH_IV3 = 64'h7465646279746573;

    localparam logic [7:0]  KMH_FIN_XOR     = 8'hff;
    localparam int unsigned KMH_LEN_SHIFT   = 56;
    localparam logic [7:0]  KMH_WORD_BYTES  = 8'd8;

    localparam int unsigned KMH_CNT_W       = 3;
    localparam logic [KMH_CNT_W-1:0] KMH_COMP_ROUNDS = 3'd2;
    localparam logic [KMH_CNT_W-1:0] KMH_FIN_ROUNDS  = 3'd4;

    function automatic t_kmh_word kmh_rotl(input t_kmh_word x, input int unsigned s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic t_kmh_lanes kmh_round(input t_kmh_lanes v);
        t_kmh_lanes r;
        r = v;
        r.v0 = r.v0 + r.v1;
        r.v1 = kmh_rotl(r.v1, 13) ^ r.v0;
        r.v0 = kmh_rotl(r.v0, 32);
        r.v2 = r.v2 + r.v3;
        r.v3 = kmh_rotl(r.v3, 16) ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = kmh_rotl(r.v3, 21) ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = kmh_rotl(r.v1, 17) ^ r.v2;
        r.v2 = kmh_rotl(r.v2, 32);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/kmh_front.sv
// ----------------------------------------------------------------------------
// kmh_front
// Accepts message requests, tracks message start and length, and builds the
// block that the round engine absorbs (full word or length/tail block).
// ----------------------------------------------------------------------------
`default_nettype none

module kmh_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [63:0]         i_msg_word,
    input  wire  [2:0]          i_tail_bytes,
    input  wire                 i_last,
    input  wire                 i_q_full,
    output logic                o_push,
    output kmh_pkg::t_kmh_entry o_entry
);

    logic       r_open;
    logic [7:0] r_len;
    logic       n_open;
    logic [7:0] n_len;
    logic       accept;
    logic [7:0] len_base;
    logic [7:0] len_new;
    logic [63:0] mask;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        len_base = r_open ? r_len : 8'd0;
        len_new  = i_last ? (len_base + {5'd0, i_tail_bytes})
                          : (len_base + kmh_pkg::KMH_WORD_BYTES);
        // keep only the tail bytes
        for (int b = 0; b < 8; b++) begin
            mask[b*8 +: 8] = (b < int'(i_tail_bytes)) ? 8'hff : 8'h00;
        end
        o_entry.start = !r_open;
        o_entry.last  = i_last;
        if (i_last) begin
            o_entry.block = ({56'd0, len_new} << kmh_pkg::KMH_LEN_SHIFT)
                          | (i_msg_word & mask);
        end else begin
            o_entry.block = i_msg_word;
        end
        n_open = r_open;
        n_len  = r_len;
        if (accept) begin
            n_open = !i_last;
            n_len  = i_last ? 8'd0 : len_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_len  <= 8'd0;
        end else begin
            r_open <= n_open;
            r_len  <= n_len;
        end
    end

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (!r_open && r_len == 8'd0))
        else $error("message still open after final request");

endmodule

`default_nettype wire

### rtl/kmh_queue.sv
// ----------------------------------------------------------------------------
// kmh_queue
// Short FIFO of classified requests between the front end and round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kmh_queue #(
    parameter int unsigned DEPTH = kmh_pkg::KMH_QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  kmh_pkg::t_kmh_entry i_entry,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output kmh_pkg::t_kmh_entry o_entry
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

    kmh_pkg::t_kmh_entry r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == Full);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/kmh_back.sv
// ----------------------------------------------------------------------------
// kmh_back
// Round engine: one SipRound per cycle on the four lanes while it is not held by a
// stalled output, compression then finalization, with a registered hash output.
// ----------------------------------------------------------------------------
`default_nettype none

module kmh_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [63:0]         i_key_low,
    input  wire  [63:0]         i_key_high,
    input  wire                 i_q_valid,
    input  kmh_pkg::t_kmh_entry i_q_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [63:0]         o_hash
);

    kmh_pkg::t_kmh_lanes r_v, n_v, rnd, base;
    logic [63:0] r_blk, n_blk;
    logic        r_last, n_last;
    logic        r_busy, n_busy;
    logic        r_final, n_final;
    logic [kmh_pkg::KMH_CNT_W-1:0] r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_hash, n_hash;
    logic        comp_end, fin_end, out_free, hold, item_done;

    assign o_out_valid = r_out_valid;
    assign o_hash      = r_hash;

    always_comb begin
        rnd       = kmh_pkg::kmh_round(r_v);
        comp_end  = r_busy && !r_final && (r_cnt == 1);
        fin_end   = r_busy && r_final && (r_cnt == 1);
        out_free  = !r_out_valid || !i_out_stall;
        hold      = fin_end && !out_free;
        item_done = (comp_end && !r_last) || (fin_end && out_free);
        o_pop     = (!r_busy || item_done) && i_q_valid;

        n_v         = r_v;
        n_blk       = r_blk;
        n_last      = r_last;
        n_busy      = r_busy;
        n_final     = r_final;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_hash      = r_hash;

        if (r_busy && !hold) begin
            n_v   = rnd;
            n_cnt = r_cnt - 1'b1;
            if (comp_end) begin
                n_v.v0 = rnd.v0 ^ r_blk;
                if (r_last) begin
                    n_v.v2  = rnd.v2 ^ {56'd0, kmh_pkg::KMH_FIN_XOR};
                    n_final = 1'b1;
                    n_cnt   = kmh_pkg::KMH_FIN_ROUNDS;
                end
            end
            if (fin_end) begin
                n_out_valid = 1'b1;
                n_hash      = rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;
            end
            if (item_done) begin
                n_busy = 1'b0;
            end
        end

        // load next request, seeding lanes from the key on message start
        base = n_v;
        if (i_q_entry.start) begin
            base.v0 = kmh_pkg::KMH_IV0 ^ i_key_low;
            base.v1 = kmh_pkg::KMH_IV1 ^ i_key_high;
            base.v2 = kmh_pkg::KMH_IV2 ^ i_key_low;
            base.v3 = kmh_pkg::KMH_IV3 ^ i_key_high;
        end
        if (o_pop) begin
            n_v     = base;
            n_v.v3  = base.v3 ^ i_q_entry.block;
            n_blk   = i_q_entry.block;
            n_last  = i_q_entry.last;
            n_busy  = 1'b1;
            n_final = 1'b0;
            n_cnt   = kmh_pkg::KMH_COMP_ROUNDS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_final     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_final     <= n_final;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_blk  <= n_blk;
        r_last <= n_last;
        r_hash <= n_hash;
    end

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("round engine busy with no rounds left");

    a_final_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_final) |-> r_last)
        else $error("finalization on a non-final request");

endmodule

`default_nettype wire

### rtl/keyed_message_hash.sv
// ----------------------------------------------------------------------------
// keyed_message_hash
// SipHash-2-4 of a streamed message under a 128-bit key held in two registers.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | i_in_valid / o_in_stall    | i_msg_word, i_tail_bytes, i_last
//  out      | o_out_valid / i_out_stall  | o_hash
//  cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  A full word gets two compression rounds in the round engine, a final request
//  two compression plus four finalization rounds, one SipRound per cycle unless held.
//  The front end takes a request every cycle until the request queue is full.
//  Output register holds the hash; the last final round waits while it is stalled.
//  Reset is synchronous and active low; keys reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_message_hash #(
    parameter int unsigned QUEUE_DEPTH = kmh_pkg::KMH_QUEUE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [63:0]                      i_msg_word,
    input  wire  [2:0]                       i_tail_bytes,
    input  wire                              i_last,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [63:0]                      o_hash,
    input  wire                              i_cfg_we,
    input  wire  [kmh_pkg::KMH_CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [63:0]                      i_cfg_data
);

    logic [63:0] r_key_low, r_key_high;
    logic        q_full, push, pop, q_valid;
    kmh_pkg::t_kmh_entry push_entry, head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kmh_pkg::KMH_CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                kmh_pkg::KMH_CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    kmh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_msg_word   (i_msg_word),
        .i_tail_bytes (i_tail_bytes),
        .i_last       (i_last),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    kmh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    kmh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_low   (r_key_low),
        .i_key_high  (r_key_high),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hash      (o_hash)
    );

endmodule

`default_nettype wire
